// ===== hw/rtl/swhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhc_pkg
// Shared types, codes and helpers of the servo wing Hall controller.
// ----------------------------------------------------------------------------
package swhc_pkg;

  localparam int SAMPLE_BITS_DEF = 12;

  localparam int KIND_W   = 3;
  localparam int HALL_W   = 12;
  localparam int DT_W     = 10;
  localparam int TRIM_W   = 9;
  localparam int DUR_W    = 16;
  localparam int PULSE_W  = 12;
  localparam int EVENT_W  = 3;
  localparam int LEVEL_W  = 12;
  localparam int RAIL_T_W = 11;
  localparam int MOVE_T_W = 12;
  localparam int REMAIN_W = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPEN   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HOME   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DETACH = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TEST   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd6;

  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_OPEN     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_CLOSED   = 3'd2;
  localparam logic [EVENT_W-1:0] EV_TIMEOUT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_TEST_END = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM         = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SIDE    = 2'd3;

  localparam logic [PULSE_W-1:0]  STOP_WIDTH = 12'd1500;
  localparam logic [RAIL_T_W-1:0] RAIL_SAT   = 11'd2047;
  localparam logic [RAIL_T_W-1:0] RAIL_LIMIT = 11'd1000;
  localparam logic [MOVE_T_W-1:0] MOVE_SAT   = 12'd4095;
  localparam logic [MOVE_T_W-1:0] MOVE_LIMIT = 12'd2000;
  localparam int RAIL_MARGIN = 15;
  localparam int MIN_SWING   = 150;
  localparam logic signed [TRIM_W:0] SPEED_OFS = 10'sd475;
  localparam logic signed [TRIM_W-1:0] TRIM_MIN = -9'sd200;
  localparam logic signed [TRIM_W-1:0] TRIM_MAX = 9'sd200;

  typedef struct packed {
    logic [LEVEL_W-1:0]       open_level;
    logic [LEVEL_W-1:0]       closed_level;
    logic signed [TRIM_W-1:0] trim_setting;
    logic                     left_side;
  } swhc_cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [HALL_W-1:0]        hall_sample;
    logic [DT_W-1:0]          elapsed_ms;
    logic                     servo_attached;
    logic signed [TRIM_W-1:0] test_trim;
    logic [DUR_W-1:0]         test_duration_ms;
  } swhc_item_t;

  typedef struct packed {
    logic                     open_f;
    logic                     opening;
    logic                     closing;
    logic                     fault;
    logic [RAIL_T_W-1:0]      rail_time;
    logic [MOVE_T_W-1:0]      move_time;
    logic signed [TRIM_W-1:0] active_trim;
    logic                     drive_on;
    logic [PULSE_W-1:0]       drive_width;
    logic                     test_active;
    logic [REMAIN_W-1:0]      test_remaining;
  } swhc_state_t;

  typedef struct packed {
    logic               servo_on;
    logic [PULSE_W-1:0] pulse_us;
    logic               wing_open;
    logic               wing_opening;
    logic               wing_closing;
    logic               sensor_fault;
    logic [EVENT_W-1:0] event_res;
  } swhc_result_t;

  function automatic logic signed [TRIM_W-1:0] clamp_trim(input logic signed [TRIM_W-1:0] t);
    logic signed [TRIM_W-1:0] r;
    if (t < TRIM_MIN) r = TRIM_MIN;
    else if (t > TRIM_MAX) r = TRIM_MAX;
    else r = t;
    return r;
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_width(input logic signed [TRIM_W-1:0] trim,
                                                     input logic signed [TRIM_W:0] ofs);
    logic signed [PULSE_W:0] s;
    s = $signed({1'b0, STOP_WIDTH}) + (PULSE_W+1)'(trim) + (PULSE_W+1)'(ofs);
    return s[PULSE_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/swhc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhc_in_if / swhc_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface swhc_in_if;
  import swhc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [HALL_W-1:0]        hall_sample;
  logic [DT_W-1:0]          elapsed_ms;
  logic                     servo_attached;
  logic signed [TRIM_W-1:0] test_trim;
  logic [DUR_W-1:0]         test_duration_ms;

  modport source (output valid, kind, hall_sample, elapsed_ms, servo_attached, test_trim,
                  test_duration_ms, input ready);
  modport sink (input valid, kind, hall_sample, elapsed_ms, servo_attached, test_trim,
                test_duration_ms, output ready);
endinterface

interface swhc_out_if;
  import swhc_pkg::*;

  logic               valid;
  logic               ready;
  logic               servo_on;
  logic [PULSE_W-1:0] pulse_us;
  logic               wing_open;
  logic               wing_opening;
  logic               wing_closing;
  logic               sensor_fault;
  logic [EVENT_W-1:0] event_res;

  modport source (output valid, servo_on, pulse_us, wing_open, wing_opening, wing_closing,
                  sensor_fault, event_res, input ready);
  modport sink (input valid, servo_on, pulse_us, wing_open, wing_opening, wing_closing,
                sensor_fault, event_res, output ready);
endinterface

// ===== hw/rtl/swhc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhc_step
// Next-state and result logic for one command or tick item.
// ----------------------------------------------------------------------------
module swhc_step #(
  parameter int SAMPLE_BITS = swhc_pkg::SAMPLE_BITS_DEF
) (
  input  swhc_pkg::swhc_cfg_t    cfg,
  input  swhc_pkg::swhc_item_t   item,
  input  swhc_pkg::swhc_state_t  st,
  input  logic [SAMPLE_BITS-1:0] swing_lo,
  input  logic [SAMPLE_BITS-1:0] swing_hi,
  output swhc_pkg::swhc_state_t  st_nxt,
  output logic [SAMPLE_BITS-1:0] swing_lo_nxt,
  output logic [SAMPLE_BITS-1:0] swing_hi_nxt,
  output swhc_pkg::swhc_result_t res
);
  import swhc_pkg::*;

  localparam int CW = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
  localparam logic [SAMPLE_BITS-1:0] SMAX    = '1;
  localparam logic [SAMPLE_BITS-1:0] RAIL_LO = SAMPLE_BITS'(RAIL_MARGIN);
  localparam logic [SAMPLE_BITS-1:0] RAIL_HI = SMAX - SAMPLE_BITS'(RAIL_MARGIN);
  localparam logic [SAMPLE_BITS-1:0] SWING_MIN = SAMPLE_BITS'(MIN_SWING);

  logic [SAMPLE_BITS-1:0] h;
  logic [CW-1:0]          h_w;
  logic [CW-1:0]          open_w;
  logic [CW-1:0]          closed_w;
  logic                   normal_pol;
  logic                   open_hit;
  logic                   closed_hit;
  logic                   at_rail;
  logic [RAIL_T_W:0]      rail_sum;
  logic [RAIL_T_W-1:0]    rail_next;
  logic [MOVE_T_W:0]      move_sum;
  logic [MOVE_T_W-1:0]    move_next;
  logic [REMAIN_W-1:0]    dt_w;
  logic [SAMPLE_BITS-1:0] lo_upd;
  logic [SAMPLE_BITS-1:0] hi_upd;
  logic                   swing_small;
  logic signed [TRIM_W:0] open_ofs;
  logic signed [TRIM_W:0] close_ofs;
  logic signed [TRIM_W-1:0] test_trim_c;
  logic [EVENT_W-1:0]     ev;

  assign h          = SAMPLE_BITS'(item.hall_sample);
  assign h_w        = CW'(h);
  assign open_w     = CW'(cfg.open_level);
  assign closed_w   = CW'(cfg.closed_level);
  assign normal_pol = cfg.open_level >= cfg.closed_level;
  assign open_hit   = normal_pol ? (h_w >= open_w) : (h_w <= open_w);
  assign closed_hit = normal_pol ? (h_w <= closed_w) : (h_w >= closed_w);
  assign at_rail    = (h <= RAIL_LO) || (h >= RAIL_HI);

  assign rail_sum  = {1'b0, st.rail_time} + (RAIL_T_W+1)'(item.elapsed_ms);
  assign rail_next = (rail_sum > {1'b0, RAIL_SAT}) ? RAIL_SAT : rail_sum[RAIL_T_W-1:0];
  assign move_sum  = {1'b0, st.move_time} + (MOVE_T_W+1)'(item.elapsed_ms);
  assign move_next = (move_sum > {1'b0, MOVE_SAT}) ? MOVE_SAT : move_sum[MOVE_T_W-1:0];
  assign dt_w      = REMAIN_W'(item.elapsed_ms);

  assign lo_upd      = (h < swing_lo) ? h : swing_lo;
  assign hi_upd      = (h > swing_hi) ? h : swing_hi;
  assign swing_small = (hi_upd >= lo_upd) && ((hi_upd - lo_upd) < SWING_MIN);

  assign open_ofs    = cfg.left_side ? SPEED_OFS : -SPEED_OFS;
  assign close_ofs   = cfg.left_side ? -SPEED_OFS : SPEED_OFS;
  assign test_trim_c = clamp_trim(item.test_trim);

  always_comb begin
    st_nxt       = st;
    swing_lo_nxt = swing_lo;
    swing_hi_nxt = swing_hi;
    ev           = EV_NONE;
    case (item.kind)
      KIND_TICK: begin
        if (at_rail) begin
          st_nxt.rail_time = rail_next;
          if (rail_next >= RAIL_LIMIT) st_nxt.fault = 1'b1;
        end else begin
          st_nxt.rail_time = '0;
        end
        if (st.test_active) begin
          if (st.test_remaining == '0) begin
            st_nxt.test_active = 1'b0;
            st_nxt.drive_on    = 1'b0;
            ev                 = EV_TEST_END;
          end else begin
            st_nxt.test_remaining = (st.test_remaining > dt_w) ? st.test_remaining - dt_w : '0;
          end
        end
        if ((st.opening || st.closing) && item.servo_attached) begin
          swing_lo_nxt     = lo_upd;
          swing_hi_nxt     = hi_upd;
          st_nxt.move_time = move_next;
          if (st.opening && open_hit) begin
            st_nxt.opening  = 1'b0;
            st_nxt.open_f   = 1'b1;
            st_nxt.fault    = 1'b0;
            st_nxt.drive_on = 1'b0;
            ev              = EV_OPEN;
          end else if (st.closing && closed_hit) begin
            st_nxt.closing  = 1'b0;
            st_nxt.fault    = 1'b0;
            st_nxt.drive_on = 1'b0;
            ev              = EV_CLOSED;
          end else if (move_next >= MOVE_LIMIT) begin
            if (swing_small) st_nxt.fault = 1'b1;
            if (st.opening) st_nxt.open_f = 1'b1;
            st_nxt.opening  = 1'b0;
            st_nxt.closing  = 1'b0;
            st_nxt.drive_on = 1'b0;
            ev              = EV_TIMEOUT;
          end
        end
      end
      KIND_OPEN: begin
        if (!st.open_f) begin
          st_nxt.opening     = 1'b1;
          st_nxt.closing     = 1'b0;
          st_nxt.move_time   = '0;
          swing_lo_nxt       = SMAX;
          swing_hi_nxt       = '0;
          st_nxt.drive_on    = 1'b1;
          st_nxt.drive_width = pulse_width(st.active_trim, open_ofs);
        end
      end
      KIND_CLOSE, KIND_HOME: begin
        if (item.kind == KIND_HOME && !open_hit && closed_hit) begin
          st_nxt.open_f = 1'b0;
        end else if (item.kind == KIND_HOME || st.open_f) begin
          st_nxt.opening     = 1'b0;
          st_nxt.closing     = 1'b1;
          st_nxt.open_f      = 1'b0;
          st_nxt.move_time   = '0;
          swing_lo_nxt       = SMAX;
          swing_hi_nxt       = '0;
          st_nxt.drive_on    = 1'b1;
          st_nxt.drive_width = pulse_width(st.active_trim, close_ofs);
        end
      end
      KIND_DETACH: begin
        st_nxt.drive_on = 1'b0;
        st_nxt.opening  = 1'b0;
        st_nxt.closing  = 1'b0;
      end
      KIND_TEST: begin
        st_nxt.opening        = 1'b0;
        st_nxt.closing        = 1'b0;
        st_nxt.active_trim    = test_trim_c;
        st_nxt.drive_on       = 1'b1;
        st_nxt.drive_width    = pulse_width(test_trim_c, '0);
        st_nxt.test_active    = 1'b1;
        st_nxt.test_remaining = REMAIN_W'(item.test_duration_ms);
      end
      KIND_LOAD: begin
        st_nxt.active_trim = clamp_trim(cfg.trim_setting);
      end
      default: begin
      end
    endcase
  end

  assign res.servo_on     = st_nxt.drive_on;
  assign res.pulse_us     = st_nxt.drive_width;
  assign res.wing_open    = st_nxt.open_f;
  assign res.wing_opening = st_nxt.opening;
  assign res.wing_closing = st_nxt.closing;
  assign res.sensor_fault = st_nxt.fault;
  assign res.event_res    = ev;

endmodule

// ===== hw/rtl/servo_wing_hall_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_wing_hall_controller
// Servo wing open/close supervisor driven by Hall samples, commands and ticks.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the input register feeds a one-pass step
// into the state and result registers, stalled only by out_ch.ready
// reset: synchronous, active low; restores register defaults and wing state
// ----------------------------------------------------------------------------
module servo_wing_hall_controller #(
  parameter int SAMPLE_BITS = swhc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  swhc_in_if.sink                            in_ch,
  swhc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [swhc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swhc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import swhc_pkg::*;

  swhc_cfg_t              cfg_r;
  swhc_item_t             item_r;
  logic                   item_v_r;
  swhc_state_t            st_r;
  swhc_state_t            st_nxt;
  logic [SAMPLE_BITS-1:0] swing_lo_r;
  logic [SAMPLE_BITS-1:0] swing_hi_r;
  logic [SAMPLE_BITS-1:0] swing_lo_nxt;
  logic [SAMPLE_BITS-1:0] swing_hi_nxt;
  swhc_result_t           res_nxt;
  swhc_result_t           res_r;
  logic                   res_v_r;
  logic                   advance;

  assign advance     = item_v_r && (!res_v_r || out_ch.ready);
  assign in_ch.ready = !item_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.open_level   <= 12'd3000;
      cfg_r.closed_level <= 12'd1000;
      cfg_r.trim_setting <= '0;
      cfg_r.left_side    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPEN_LEVEL:   cfg_r.open_level   <= cfg_data[LEVEL_W-1:0];
        REG_CLOSED_LEVEL: cfg_r.closed_level <= cfg_data[LEVEL_W-1:0];
        REG_TRIM:         cfg_r.trim_setting <= $signed(cfg_data[TRIM_W-1:0]);
        REG_LEFT_SIDE:    cfg_r.left_side    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.kind             <= in_ch.kind;
      item_r.hall_sample      <= in_ch.hall_sample;
      item_r.elapsed_ms       <= in_ch.elapsed_ms;
      item_r.servo_attached   <= in_ch.servo_attached;
      item_r.test_trim        <= in_ch.test_trim;
      item_r.test_duration_ms <= in_ch.test_duration_ms;
    end
  end

  swhc_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .cfg          (cfg_r),
    .item         (item_r),
    .st           (st_r),
    .swing_lo     (swing_lo_r),
    .swing_hi     (swing_hi_r),
    .st_nxt       (st_nxt),
    .swing_lo_nxt (swing_lo_nxt),
    .swing_hi_nxt (swing_hi_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.open_f         <= 1'b0;
      st_r.opening        <= 1'b0;
      st_r.closing        <= 1'b0;
      st_r.fault          <= 1'b0;
      st_r.rail_time      <= '0;
      st_r.move_time      <= '0;
      st_r.active_trim    <= '0;
      st_r.drive_on       <= 1'b0;
      st_r.drive_width    <= STOP_WIDTH;
      st_r.test_active    <= 1'b0;
      st_r.test_remaining <= '0;
      swing_lo_r          <= '1;
      swing_hi_r          <= '0;
      res_v_r             <= 1'b0;
    end else begin
      if (advance) begin
        st_r       <= st_nxt;
        swing_lo_r <= swing_lo_nxt;
        swing_hi_r <= swing_hi_nxt;
        res_v_r    <= 1'b1;
      end else if (out_ch.ready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = res_v_r;
  assign out_ch.servo_on     = res_r.servo_on;
  assign out_ch.pulse_us     = res_r.pulse_us;
  assign out_ch.wing_open    = res_r.wing_open;
  assign out_ch.wing_opening = res_r.wing_opening;
  assign out_ch.wing_closing = res_r.wing_closing;
  assign out_ch.sensor_fault = res_r.sensor_fault;
  assign out_ch.event_res    = res_r.event_res;

`ifndef SYNTH
  a_open_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.opening && st_r.open_f))
    else $error("wing open and opening at once");

  a_move_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.opening && st_r.closing))
    else $error("wing opening and closing at once");

  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.drive_width >= 12'd825 && st_r.drive_width <= 12'd2175)
    else $error("pulse width out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && !out_ch.ready |=> $stable(st_r) && $stable(swing_lo_r))
    else $error("state advanced while result stalled");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the servo wing Hall controller. Short directed runs
// cover each command, arrival at both ends, timeout with a stuck sensor, rail
// faults, stop test timing and trim clamping. Random movement, stop test and
// rail sequences then run under several threshold, trim and side settings.
// Every result transaction is compared field by field with a wing model kept
// inside the bench; most runs add random gaps on the command side and random stalls on
// the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import swhc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
  localparam int HALL_MAX = (1 << HALL_W) - 1;
  localparam int DRIVE_OFS_US = 475;
  localparam int MOVE_CAP_MS = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  swhc_in_if  in_ch ();
  swhc_out_if out_ch ();

  servo_wing_hall_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  int   lvl_open, lvl_closed, trim_reg;
  logic left_wing;

  logic wing_is_open, moving_open, moving_closed, fault_seen, drive_active, test_running;
  int   rail_ms, move_ms, swing_min, swing_max, trim_now, width_us, test_ms_left;

  swhc_result_t expected_q[$];
  int error_count;
  int result_count;
  int in_gap_pct;
  int out_stall_pct;
  int out_stall_left;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", result_count, msg);
    error_count++;
  endtask

  function automatic int limit_trim(input int t);
    if (t < int'(TRIM_MIN)) return int'(TRIM_MIN);
    if (t > int'(TRIM_MAX)) return int'(TRIM_MAX);
    return t;
  endfunction

  function automatic logic beyond_open(input int v);
    return (lvl_open >= lvl_closed) ? (v >= lvl_open) : (v <= lvl_open);
  endfunction

  function automatic logic beyond_closed(input int v);
    return (lvl_open >= lvl_closed) ? (v <= lvl_closed) : (v >= lvl_closed);
  endfunction

  function automatic void drive_pulse(input int ofs);
    drive_active = 1'b1;
    width_us = (int'(STOP_WIDTH) + trim_now + ofs) & 'hFFF;
  endfunction

  function automatic void restart_move();
    move_ms = 0;
    swing_min = HALL_MAX;
    swing_max = 0;
  endfunction

  function automatic void begin_closing();
    moving_open = 1'b0;
    moving_closed = 1'b1;
    wing_is_open = 1'b0;
    restart_move();
    drive_pulse(left_wing ? -DRIVE_OFS_US : DRIVE_OFS_US);
  endfunction

  function automatic logic [EVENT_W-1:0] tick_update(input int h, input int dt, input logic att);
    logic [EVENT_W-1:0] ev;
    ev = EV_NONE;
    if (h <= RAIL_MARGIN || h >= HALL_MAX - RAIL_MARGIN) begin
      rail_ms = (rail_ms + dt > int'(RAIL_SAT)) ? int'(RAIL_SAT) : rail_ms + dt;
      if (rail_ms >= int'(RAIL_LIMIT)) fault_seen = 1'b1;
    end else begin
      rail_ms = 0;
    end
    if (test_running) begin
      if (test_ms_left == 0) begin
        test_running = 1'b0;
        drive_active = 1'b0;
        ev = EV_TEST_END;
      end else begin
        test_ms_left = (test_ms_left > dt) ? test_ms_left - dt : 0;
      end
    end
    if ((moving_open || moving_closed) && att) begin
      if (h < swing_min) swing_min = h;
      if (h > swing_max) swing_max = h;
      move_ms = (move_ms + dt > int'(MOVE_SAT)) ? int'(MOVE_SAT) : move_ms + dt;
      if (moving_open && beyond_open(h)) begin
        moving_open = 1'b0;
        wing_is_open = 1'b1;
        fault_seen = 1'b0;
        drive_active = 1'b0;
        ev = EV_OPEN;
      end else if (moving_closed && beyond_closed(h)) begin
        moving_closed = 1'b0;
        fault_seen = 1'b0;
        drive_active = 1'b0;
        ev = EV_CLOSED;
      end else if (move_ms >= MOVE_CAP_MS) begin
        if (swing_max - swing_min < MIN_SWING) fault_seen = 1'b1;
        if (moving_open) wing_is_open = 1'b1;
        moving_open = 1'b0;
        moving_closed = 1'b0;
        drive_active = 1'b0;
        ev = EV_TIMEOUT;
      end
    end
    return ev;
  endfunction

  function automatic swhc_result_t wing_step(input swhc_item_t it);
    swhc_result_t r;
    logic [EVENT_W-1:0] ev;
    ev = EV_NONE;
    case (it.kind)
      KIND_TICK: begin
        ev = tick_update(int'(it.hall_sample), int'(it.elapsed_ms), it.servo_attached);
      end
      KIND_OPEN: begin
        if (!wing_is_open) begin
          moving_open = 1'b1;
          moving_closed = 1'b0;
          restart_move();
          drive_pulse(left_wing ? DRIVE_OFS_US : -DRIVE_OFS_US);
        end
      end
      KIND_CLOSE: begin
        if (wing_is_open) begin_closing();
      end
      KIND_HOME: begin
        if (!beyond_open(int'(it.hall_sample)) && beyond_closed(int'(it.hall_sample)))
          wing_is_open = 1'b0;
        else
          begin_closing();
      end
      KIND_DETACH: begin
        drive_active = 1'b0;
        moving_open = 1'b0;
        moving_closed = 1'b0;
      end
      KIND_TEST: begin
        moving_open = 1'b0;
        moving_closed = 1'b0;
        trim_now = limit_trim(int'($signed(it.test_trim)));
        drive_pulse(0);
        test_running = 1'b1;
        test_ms_left = int'(it.test_duration_ms);
      end
      KIND_LOAD: begin
        trim_now = limit_trim(trim_reg);
      end
      default: begin
      end
    endcase
    r.servo_on = drive_active;
    r.pulse_us = width_us[PULSE_W-1:0];
    r.wing_open = wing_is_open;
    r.wing_opening = moving_open;
    r.wing_closing = moving_closed;
    r.sensor_fault = fault_seen;
    r.event_res = ev;
    return r;
  endfunction

  function automatic swhc_item_t make_item(input logic [KIND_W-1:0] kind, input int hall,
                                           input int dt, input logic att);
    swhc_item_t it;
    it.kind = kind;
    it.hall_sample = hall[HALL_W-1:0];
    it.elapsed_ms = dt[DT_W-1:0];
    it.servo_attached = att;
    it.test_trim = TRIM_W'($urandom);
    it.test_duration_ms = DUR_W'($urandom_range(0, 3000));
    return it;
  endfunction

  function automatic swhc_item_t test_item(input logic [TRIM_W-1:0] trim, input int dur);
    swhc_item_t it;
    it = make_item(KIND_TEST, $urandom_range(0, HALL_MAX), $urandom_range(0, 1000),
                   1'($urandom));
    it.test_trim = trim;
    it.test_duration_ms = dur[DUR_W-1:0];
    return it;
  endfunction

  function automatic int near_level(input int level, input int spread);
    int v;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > HALL_MAX) v = HALL_MAX;
    return v;
  endfunction

  function automatic int rand_dt();
    return ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 1000))
                                       : int'($urandom_range(0, 400));
  endfunction

  task automatic send_item(input swhc_item_t it);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.hall_sample <= it.hall_sample;
    in_ch.elapsed_ms <= it.elapsed_ms;
    in_ch.servo_attached <= it.servo_attached;
    in_ch.test_trim <= it.test_trim;
    in_ch.test_duration_ms <= it.test_duration_ms;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(wing_step(it));
  endtask

  task automatic issue(input logic [KIND_W-1:0] kind, input int hall, input int dt,
                       input logic att);
    send_item(make_item(kind, hall, dt, att));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input int open_v, input int closed_v,
                              input logic [TRIM_W-1:0] trim_v, input logic left_v);
    cfg_we <= 1'b1;
    cfg_index <= REG_OPEN_LEVEL;
    cfg_data <= open_v[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_CLOSED_LEVEL;
    cfg_data <= closed_v[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_TRIM;
    cfg_data <= {3'($urandom), trim_v};
    @(posedge clk);
    cfg_index <= REG_LEFT_SIDE;
    cfg_data <= {11'($urandom), left_v};
    @(posedge clk);
    cfg_we <= 1'b0;
    lvl_open = open_v;
    lvl_closed = closed_v;
    trim_reg = int'($signed(trim_v));
    left_wing = left_v;
  endtask

  task automatic run_random(input int n_items, input logic quiet);
    int sent, steps, pos, target, h, pick;
    logic stuck;
    swhc_item_t it;
    sent = 0;
    while (sent < n_items) begin
      if (quiet) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
      end else begin
        pick = $urandom_range(0, 3);
        in_gap_pct = 8 * pick;
        out_stall_pct = 8 * int'($urandom_range(0, 3));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 2))
          0: begin
            issue(KIND_OPEN, $urandom_range(0, HALL_MAX), rand_dt(), 1'($urandom));
            target = lvl_open;
          end
          1: begin
            issue(KIND_CLOSE, $urandom_range(0, HALL_MAX), rand_dt(), 1'($urandom));
            target = lvl_closed;
          end
          default: begin
            issue(KIND_HOME, ($urandom_range(0, 1) == 0) ? near_level(lvl_closed, 60)
                                                          : int'($urandom_range(0, HALL_MAX)),
                  rand_dt(), 1'($urandom));
            target = lvl_closed;
          end
        endcase
        pos = $urandom_range(0, HALL_MAX);
        stuck = ($urandom_range(0, 4) == 0);
        steps = $urandom_range(1, 14);
        repeat (steps) begin
          if (stuck) begin
            h = near_level(pos, 60);
          end else begin
            pos = near_level(pos + (target - pos) / 3, 80);
            h = pos;
          end
          issue(KIND_TICK, h, rand_dt(), $urandom_range(0, 9) != 0);
        end
        sent += steps + 1;
      end else if (pick < 60) begin
        if ($urandom_range(0, 2) == 0) begin
          issue(KIND_OPEN, $urandom_range(0, HALL_MAX), rand_dt(), 1'b1);
          sent++;
        end
        send_item(test_item(TRIM_W'($urandom), ($urandom_range(0, 7) == 0)
                            ? int'($urandom_range(0, 65535)) : int'($urandom_range(0, 2500))));
        steps = $urandom_range(1, 6);
        repeat (steps) begin
          issue(KIND_TICK, ($urandom_range(0, 1) == 0) ? near_level(lvl_open, 100)
                                                        : int'($urandom_range(0, HALL_MAX)),
                $urandom_range(0, 1000), 1'($urandom));
        end
        sent += steps + 1;
      end else if (pick < 72) begin
        steps = $urandom_range(1, 6);
        repeat (steps) begin
          h = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, RAIL_MARGIN))
                                          : int'($urandom_range(HALL_MAX - RAIL_MARGIN, HALL_MAX));
          issue(KIND_TICK, h, $urandom_range(100, 1000), 1'($urandom));
        end
        sent += steps;
      end else if (pick < 84) begin
        case ($urandom_range(0, 2))
          0: issue(KIND_LOAD, $urandom_range(0, HALL_MAX), rand_dt(), 1'($urandom));
          1: issue(KIND_DETACH, $urandom_range(0, HALL_MAX), rand_dt(), 1'($urandom));
          default: issue(KIND_UNUSED, $urandom_range(0, HALL_MAX), rand_dt(), 1'($urandom));
        endcase
        sent++;
      end else begin
        it = make_item(KIND_W'($urandom), $urandom_range(0, HALL_MAX),
                       $urandom_range(0, 1000), 1'($urandom));
        it.test_duration_ms = DUR_W'($urandom);
        send_item(it);
        sent++;
      end
    end
  endtask

  task automatic test_commands();
    in_gap_pct = 20;
    out_stall_pct = 20;
    issue(KIND_TICK, 2048, 0, 1'b1);
    issue(KIND_UNUSED, 2048, 0, 1'b1);
    issue(KIND_OPEN, 2000, 0, 1'b1);
    issue(KIND_TICK, 3500, 1000, 1'b0);
    issue(KIND_TICK, 3000, 1000, 1'b1);
    issue(KIND_OPEN, 3000, 0, 1'b1);
    issue(KIND_CLOSE, 3000, 0, 1'b1);
    issue(KIND_TICK, 1000, 7, 1'b1);
    issue(KIND_HOME, 1000, 0, 1'b1);
    issue(KIND_HOME, 3500, 0, 1'b1);
    issue(KIND_DETACH, 2000, 0, 1'b1);
  endtask

  task automatic test_timeout_and_rail();
    issue(KIND_OPEN, 2000, 0, 1'b1);
    issue(KIND_TICK, 2000, 1000, 1'b1);
    issue(KIND_TICK, 2100, 1000, 1'b1);
    issue(KIND_CLOSE, 2100, 0, 1'b1);
    issue(KIND_TICK, 500, 10, 1'b1);
    issue(KIND_TICK, 0, 600, 1'b1);
    issue(KIND_TICK, HALL_MAX, 600, 1'b1);
    issue(KIND_TICK, HALL_MAX, 1000, 1'b1);
  endtask

  task automatic test_stop_sequence();
    send_item(test_item(9'h100, 1000));
    issue(KIND_TICK, 2000, 1000, 1'b1);
    issue(KIND_TICK, 2000, 0, 1'b1);
    send_item(test_item(9'h0FF, 0));
    issue(KIND_OPEN, 2000, 0, 1'b1);
    issue(KIND_TICK, 3100, 1, 1'b1);
    send_item(test_item(9'h100, 0));
    issue(KIND_CLOSE, 3100, 0, 1'b1);
    issue(KIND_DETACH, 3100, 0, 1'b1);
    issue(KIND_TICK, 2000, 5, 1'b1);
  endtask

  task automatic test_settings_sweep();
    int a, b;
    wait_idle();
    write_config(0, HALL_MAX, 9'h100, 1'b0);
    issue(KIND_LOAD, 2048, 0, 1'b1);
    run_random(120, 1'b0);
    wait_idle();
    write_config(HALL_MAX, 0, 9'h0FF, 1'b1);
    issue(KIND_LOAD, 2048, 0, 1'b1);
    run_random(120, 1'b0);
    repeat (3) begin
      wait_idle();
      a = $urandom_range(0, HALL_MAX);
      b = ($urandom_range(0, 5) == 0) ? a : int'($urandom_range(0, HALL_MAX));
      write_config(a, b, TRIM_W'($urandom), 1'($urandom));
      run_random(120, 1'b0);
    end
  endtask

  task automatic test_full_rate();
    in_gap_pct = 0;
    out_stall_pct = 0;
    wait_idle();
    write_config(2800, 1200, TRIM_W'($urandom), 1'($urandom));
    issue(KIND_LOAD, 2048, 0, 1'b1);
    run_random(150, 1'b1);
  endtask

  always @(posedge clk) begin : result_check
    swhc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
      end else begin
        want = expected_q.pop_front();
        if (out_ch.servo_on !== want.servo_on)
          report_mismatch($sformatf("servo_on got %b want %b", out_ch.servo_on, want.servo_on));
        if (out_ch.pulse_us !== want.pulse_us)
          report_mismatch($sformatf("pulse_us got %0d want %0d", out_ch.pulse_us, want.pulse_us));
        if (out_ch.wing_open !== want.wing_open)
          report_mismatch($sformatf("wing_open got %b want %b", out_ch.wing_open,
                                    want.wing_open));
        if (out_ch.wing_opening !== want.wing_opening)
          report_mismatch($sformatf("wing_opening got %b want %b", out_ch.wing_opening,
                                    want.wing_opening));
        if (out_ch.wing_closing !== want.wing_closing)
          report_mismatch($sformatf("wing_closing got %b want %b", out_ch.wing_closing,
                                    want.wing_closing));
        if (out_ch.sensor_fault !== want.sensor_fault)
          report_mismatch($sformatf("sensor_fault got %b want %b", out_ch.sensor_fault,
                                    want.sensor_fault));
        if (out_ch.event_res !== want.event_res)
          report_mismatch($sformatf("event_res got %0d want %0d", out_ch.event_res,
                                    want.event_res));
      end
      result_count++;
    end
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_ch.ready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_stall_left = $urandom_range(0, 17);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.kind <= KIND_TICK;
    in_ch.hall_sample <= '0;
    in_ch.elapsed_ms <= '0;
    in_ch.servo_attached <= 1'b0;
    in_ch.test_trim <= '0;
    in_ch.test_duration_ms <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_OPEN_LEVEL;
    cfg_data <= '0;
    rst_n <= 1'b0;
    error_count = 0;
    result_count = 0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    out_stall_left = 0;
    lvl_open = 3000;
    lvl_closed = 1000;
    trim_reg = 0;
    left_wing = 1'b1;
    wing_is_open = 1'b0;
    moving_open = 1'b0;
    moving_closed = 1'b0;
    fault_seen = 1'b0;
    drive_active = 1'b0;
    test_running = 1'b0;
    rail_ms = 0;
    move_ms = 0;
    swing_min = HALL_MAX;
    swing_max = 0;
    trim_now = 0;
    width_us = int'(STOP_WIDTH);
    test_ms_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_commands();
    test_timeout_and_rail();
    test_stop_sequence();
    test_settings_sweep();
    test_full_rate();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== servo_wing_hall_controller.f =====
hw/rtl/swhc_pkg.sv
hw/rtl/swhc_if.sv
hw/rtl/swhc_step.sv
hw/rtl/servo_wing_hall_controller.sv
tb/sv/tb_top.sv
